// File: rtl/tobq_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp-ordered buffer queue package
// Entry layout, action codes and sequencer states shared by the queue RTL.
// ----------------------------------------------------------------------------
package tobq_pkg;

  localparam int StampW = 64;
  localparam int IndexW = 8;
  localparam int AddrW  = 64;
  localparam int ActW   = 3;
  localparam int CountW = 6;

  // One queue entry as it is held in the entry RAM.
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [IndexW-1:0] index;
    logic [AddrW-1:0]  addr;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [ActW-1:0] {
    ACT_APPEND = 3'd0,
    ACT_SORTED = 3'd1,
    ACT_POP    = 3'd2,
    ACT_FIND   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_POP
  } state_t;

endpackage

// File: rtl/tobq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tobq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/timestamp_ordered_buffer_queue.sv
// ----------------------------------------------------------------------------
// Timestamp-ordered buffer queue
// Bounded queue of frame buffer entries with append, sorted insert, pop,
// find by index and clear, built around one entry RAM and one comparator.
// ----------------------------------------------------------------------------
// An action is transferred when start is high and busy is low. Its result is
// shown for exactly one cycle with done high, and the receiver cannot stall
// it. Clear, unused action codes, a pop of an empty queue and an insert into
// a full queue finish at the transfer: busy never rises and done follows in
// the next cycle. Append holds busy through the S_PUT state and a pop of a
// non-empty queue through the S_POP state. A find holds busy while the
// entries are read one per cycle from the head, until a match or the tail.
// A sorted insert scans the same way, then moves the entries behind the
// insertion point back by one place, one per cycle, and then writes the new
// entry. The scan stops at the insertion point, which is where the shift
// ends. This sequencing follows from the single read and single write port
// of the entry RAM and the single comparator that every scan goes through.
// The queue is a ring in the RAM, so a pop moves no entries; it advances the
// head pointer and lowers the count.
// ----------------------------------------------------------------------------
module timestamp_ordered_buffer_queue #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tobq_pkg::ActW-1:0]     action,
  input  logic [tobq_pkg::StampW-1:0]   stamp,
  input  logic [tobq_pkg::IndexW-1:0]   slot_index,
  input  logic [tobq_pkg::AddrW-1:0]    buffer_addr,
  output logic                          done,
  output logic                          entry_valid,
  output logic [tobq_pkg::StampW-1:0]   out_stamp,
  output logic [tobq_pkg::IndexW-1:0]   out_index,
  output logic [tobq_pkg::AddrW-1:0]    out_addr,
  output logic                          found,
  output logic                          dropped,
  output logic [tobq_pkg::CountW-1:0]   entry_count
);

  import tobq_pkg::*;

  // Ring addresses need AW bits; logical positions and the count must also
  // hold DEPTH itself.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  // Map a logical position (0 is the head) to a RAM address. The sum stays
  // below twice DEPTH, so one compare and subtract wraps it.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;

  // Request captured at the transfer.
  logic              req_sorted;
  logic [StampW-1:0] req_stamp;
  logic [IndexW-1:0] req_index;
  logic [AddrW-1:0]  req_addr;

  // Sequencer registers. During a scan, idx_a is the next position to read
  // and idx_b the position whose data is on the RAM output when vld is set.
  // During the shift, idx_a is the next source and idx_b the destination of
  // the data now on the RAM output; more marks sources still to read.
  logic [CW-1:0] idx_a, idx_a_next;
  logic [CW-1:0] idx_b, idx_b_next;
  logic          vld, vld_next;
  logic          more, more_next;
  logic [CW-1:0] pos, pos_next;

  // RAM side.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  entry_t            rd_entry;
  entry_t            ins_entry;

  // Shared comparator and scan decision.
  logic          hit;
  logic [CW-1:0] scan_pos;
  logic          full;

  // Result of the action that finishes this cycle.
  logic              fin;
  logic              fin_valid;
  logic [StampW-1:0] fin_stamp;
  logic [IndexW-1:0] fin_index;
  logic [AddrW-1:0]  fin_addr;
  logic              fin_found;
  logic              fin_drop;

  assign rd_entry  = entry_t'(ram_rdata);
  assign ins_entry = '{stamp: req_stamp, index: req_index, addr: req_addr};
  assign full      = (count == FULL);
  assign busy      = (state != S_IDLE);

  // The one compare unit: timestamp order for a sorted insert, index match
  // for a find.
  assign hit = vld && (req_sorted ? (req_stamp < rd_entry.stamp)
                                  : (rd_entry.index == req_index));
  assign scan_pos = hit ? idx_b : count;

  tobq_ram #(
    .WIDTH (EntryW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
      vld   <= 1'b0;
      more  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      vld   <= vld_next;
      more  <= more_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    idx_a <= idx_a_next;
    idx_b <= idx_b_next;
    pos   <= pos_next;
    if (state == S_IDLE && start) begin
      req_sorted <= (action == ACT_SORTED);
      req_stamp  <= stamp;
      req_index  <= slot_index;
      req_addr   <= buffer_addr;
    end
    if (fin) begin
      entry_valid <= fin_valid;
      out_stamp   <= fin_stamp;
      out_index   <= fin_index;
      out_addr    <= fin_addr;
      found       <= fin_found;
      dropped     <= fin_drop;
      entry_count <= CountW'(count_next);
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    head_next  = head;
    idx_a_next = idx_a;
    idx_b_next = idx_b;
    vld_next   = vld;
    more_next  = more;
    pos_next   = pos;

    ram_we    = 1'b0;
    ram_raddr = ring_addr(head, idx_a);
    ram_waddr = ring_addr(head, idx_b);
    ram_wdata = rd_entry;

    fin       = 1'b0;
    fin_valid = 1'b0;
    fin_stamp = '0;
    fin_index = '0;
    fin_addr  = '0;
    fin_found = 1'b0;
    fin_drop  = 1'b0;

    case (state)
      S_IDLE: begin
        // Read the head ahead of time so that a pop finds it next cycle.
        ram_raddr = head;
        if (start) begin
          case (action)
            ACT_APPEND: begin
              if (full) begin
                fin      = 1'b1;
                fin_drop = 1'b1;
              end else begin
                pos_next   = count;
                state_next = S_PUT;
              end
            end
            ACT_SORTED: begin
              if (full) begin
                fin      = 1'b1;
                fin_drop = 1'b1;
              end else begin
                idx_a_next = '0;
                vld_next   = 1'b0;
                state_next = S_SCAN;
              end
            end
            ACT_POP: begin
              if (count == '0) begin
                fin = 1'b1;
              end else begin
                state_next = S_POP;
              end
            end
            ACT_FIND: begin
              idx_a_next = '0;
              vld_next   = 1'b0;
              state_next = S_SCAN;
            end
            ACT_CLEAR: begin
              count_next = '0;
              head_next  = '0;
              fin        = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit || idx_a == count) begin
          vld_next = 1'b0;
          if (!req_sorted) begin
            fin        = 1'b1;
            fin_found  = hit;
            state_next = S_IDLE;
          end else if (scan_pos == count) begin
            pos_next   = count;
            state_next = S_PUT;
          end else begin
            pos_next   = scan_pos;
            idx_a_next = count - ONE;
            more_next  = 1'b1;
            state_next = S_SHIFT;
          end
        end else begin
          vld_next   = 1'b1;
          idx_b_next = idx_a;
          idx_a_next = idx_a + ONE;
        end
      end

      S_SHIFT: begin
        // Each cycle writes the entry read last cycle, if any, one place back and,
        // while sources remain, reads the next one toward the insertion point. The
        // source stops at the insertion point, so the read address stays inside the ring.
        ram_we = vld;
        if (more) begin
          vld_next   = 1'b1;
          idx_b_next = idx_a + ONE;
          if (idx_a != pos) begin
            idx_a_next = idx_a - ONE;
          end
          more_next  = (idx_a != pos);
        end else begin
          vld_next   = 1'b0;
          state_next = S_PUT;
        end
      end

      S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = ring_addr(head, pos);
        ram_wdata  = ins_entry;
        count_next = count + ONE;
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      S_POP: begin
        fin        = 1'b1;
        fin_valid  = 1'b1;
        fin_stamp  = rd_entry.stamp;
        fin_index  = rd_entry.index;
        fin_addr   = rd_entry.addr;
        head_next  = ring_addr(head, ONE);
        count_next = count - ONE;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The count can never pass the capacity of the ring.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count above capacity");

  // The shift only runs when the insertion point lies inside the queue.
  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (pos < count))
    else $error("shift entered with insertion point at or past the tail");

  // The RAM is written only while moving entries or placing the new one.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SHIFT || state == S_PUT))
    else $error("entry RAM written outside an insert");

  // A pop that returns an entry leaves one entry fewer behind.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (count == $past(count) - ONE))
    else $error("pop did not lower the count by one");

endmodule
